### design/ssdp_pkg.sv
// ----------------------------------------------------------------------------
// SSDP line scanner package
// Shared constants, status codes, the result word type and the status line
// lookup used by the scan core and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package ssdp_pkg;

    // Length of the "HTTP/1.1 200 OK" CR LF line and the minimum payload size
    localparam int unsigned HDR_LEN  = 17;
    localparam int unsigned MIN_LEN  = 22;
    localparam int unsigned MAX_DATA_DEF = 256;

    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_NUL  = 8'h00;

    // Status codes reported on the final word
    localparam logic [2:0] ST_COMPLETE  = 3'd0;
    localparam logic [2:0] ST_TRUNCATED = 3'd1;
    localparam logic [2:0] ST_SHORT     = 3'd2;
    localparam logic [2:0] ST_MISMATCH  = 3'd3;
    localparam logic [2:0] ST_NO_LINE   = 3'd4;

    typedef struct packed {
        logic [7:0] body_byte;
        logic [7:0] body_offset;
        logic       is_body;
        logic       done_res;
        logic [2:0] status;
        logic [7:0] capture_length;
    } t_result;

    // Expected character of the status line at a given position
    function automatic logic [7:0] status_char(input logic [4:0] idx);
        logic [7:0] c;
        begin
            case (idx)
                5'd0:    c = "H";
                5'd1:    c = "T";
                5'd2:    c = "T";
                5'd3:    c = "P";
                5'd4:    c = "/";
                5'd5:    c = "1";
                5'd6:    c = ".";
                5'd7:    c = "1";
                5'd8:    c = " ";
                5'd9:    c = "2";
                5'd10:   c = "0";
                5'd11:   c = "0";
                5'd12:   c = " ";
                5'd13:   c = "O";
                5'd14:   c = "K";
                5'd15:   c = CHAR_CR;
                5'd16:   c = CHAR_LF;
                default: c = CHAR_NUL;
            endcase
            return c;
        end
    endfunction

endpackage

`default_nettype wire

### design/ssdp_scan.sv
// ----------------------------------------------------------------------------
// SSDP scan core
// Holds the per-packet scan state and computes the result word for the
// current payload byte; state advances only when a word is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module ssdp_scan
    import ssdp_pkg::*;
#(
    parameter int unsigned MAX_DATA = MAX_DATA_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_advance,
    input  wire logic [7:0] i_payload_byte,
    input  wire logic       i_last_byte,
    output t_result         o_res
);

    localparam logic [8:0] HDR_LEN_W  = 9'(HDR_LEN);
    localparam logic [8:0] MIN_IDX_W  = 9'(MIN_LEN - 1);
    localparam logic [8:0] WINDOW_W   = 9'(MAX_DATA);
    localparam logic [8:0] COUNT_MAX  = 9'h1FF;

    logic [8:0] r_byte_count, n_byte_count;
    logic       r_header_ok, n_header_ok;
    logic       r_scan_stopped, n_scan_stopped;
    logic       r_pending_cr, n_pending_cr;
    logic       r_line_empty, n_line_empty;
    logic [7:0] r_lines_length, n_lines_length;
    logic       r_end_seen, n_end_seen;

    // Decode the byte against the state and form the next state
    always_comb begin
        logic [8:0] pos;
        logic       handled;
        pos            = r_byte_count - HDR_LEN_W;
        handled        = 1'b0;
        n_byte_count   = r_byte_count;
        n_header_ok    = r_header_ok;
        n_scan_stopped = r_scan_stopped;
        n_pending_cr   = r_pending_cr;
        n_line_empty   = r_line_empty;
        n_lines_length = r_lines_length;
        n_end_seen     = r_end_seen;

        o_res.body_byte      = i_payload_byte;
        o_res.body_offset    = '0;
        o_res.is_body        = 1'b0;
        o_res.done_res       = i_last_byte;
        o_res.status         = ST_COMPLETE;
        o_res.capture_length = '0;

        if (r_byte_count < HDR_LEN_W) begin
            if (i_payload_byte != status_char(r_byte_count[4:0])) begin
                n_header_ok = 1'b0;
            end
        end else begin
            if (pos < WINDOW_W) begin
                o_res.is_body     = 1'b1;
                o_res.body_offset = pos[7:0];
            end
            if (!r_scan_stopped) begin
                // Complete a pending CR, or demote it to an ordinary character
                if (r_pending_cr) begin
                    n_pending_cr = 1'b0;
                    if (i_payload_byte == CHAR_LF) begin
                        handled        = 1'b1;
                        n_lines_length = 8'(pos - 9'd1);
                        if (r_line_empty) begin
                            n_end_seen     = 1'b1;
                            n_scan_stopped = 1'b1;
                        end else begin
                            n_line_empty = 1'b1;
                        end
                    end else begin
                        n_line_empty = 1'b0;
                    end
                end
                if (!handled) begin
                    if (pos >= WINDOW_W) begin
                        n_scan_stopped = 1'b1;
                    end else if (i_payload_byte == CHAR_CR) begin
                        n_pending_cr = 1'b1;
                    end else if (i_payload_byte == CHAR_NUL || i_payload_byte[7]) begin
                        n_scan_stopped = 1'b1;
                    end else begin
                        n_line_empty = 1'b0;
                    end
                end
            end
        end

        // Advance the byte count, saturating
        if (r_byte_count != COUNT_MAX) begin
            n_byte_count = r_byte_count + 9'd1;
        end

        // Report status on the final byte and clear for the next packet
        if (i_last_byte) begin
            if (r_byte_count < MIN_IDX_W) begin
                o_res.status = ST_SHORT;
            end else if (!n_header_ok) begin
                o_res.status = ST_MISMATCH;
            end else if (n_lines_length == 8'd0) begin
                o_res.status = ST_NO_LINE;
            end else begin
                o_res.status         = n_end_seen ? ST_COMPLETE : ST_TRUNCATED;
                o_res.capture_length = n_lines_length;
            end
            n_byte_count   = '0;
            n_header_ok    = 1'b1;
            n_scan_stopped = 1'b0;
            n_pending_cr   = 1'b0;
            n_line_empty   = 1'b1;
            n_lines_length = '0;
            n_end_seen     = 1'b0;
        end
    end

    // Hold the state; update on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count   <= '0;
            r_header_ok    <= 1'b1;
            r_scan_stopped <= 1'b0;
            r_pending_cr   <= 1'b0;
            r_line_empty   <= 1'b1;
            r_lines_length <= '0;
            r_end_seen     <= 1'b0;
        end else if (i_advance) begin
            r_byte_count   <= n_byte_count;
            r_header_ok    <= n_header_ok;
            r_scan_stopped <= n_scan_stopped;
            r_pending_cr   <= n_pending_cr;
            r_line_empty   <= n_line_empty;
            r_lines_length <= n_lines_length;
            r_end_seen     <= n_end_seen;
        end
    end

endmodule

`default_nettype wire

### design/ssdp_response_line_scanner_top.sv
// A result word is registered in the output register, or in the skid entry while the output stalls.
// Throughput: 1 byte per cycle while o_stall is low; the scan core handles each byte in one pass.
// A two-entry output buffer takes one more input word while the output is stalled.
// Reset: synchronous, active low; clears the scan state and the valid bits of both output entries.
// ----------------------------------------------------------------------------
// SSDP response line scanner
// Checks the HTTP status line of an SSDP reply, scans the body for complete
// lines and reports status and capture length on the final byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ssdp_response_line_scanner_top
    import ssdp_pkg::*;
#(
    parameter int unsigned MAX_DATA = MAX_DATA_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_payload_byte,
    input  wire logic       i_last_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_body_byte,
    output logic [7:0]      o_body_offset,
    output logic            o_is_body,
    output logic            o_done_res,
    output logic [2:0]      o_status,
    output logic [7:0]      o_capture_length
);

    logic    in_acc;
    logic    out_free;
    t_result scan_res;
    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;

    assign o_stall  = r_skid_valid;
    assign in_acc   = i_valid && !r_skid_valid;
    assign out_free = !r_out_valid || !i_stall;

    ssdp_scan #(
        .MAX_DATA(MAX_DATA)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (in_acc),
        .i_payload_byte(i_payload_byte),
        .i_last_byte   (i_last_byte),
        .o_res         (scan_res)
    );

    // Output register with a skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_acc;
            end
        end else if (in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload moves with the valid bits; no reset needed
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : scan_res;
        end else if (in_acc) begin
            r_skid <= scan_res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_body_byte      = r_out.body_byte;
    assign o_body_offset    = r_out.body_offset;
    assign o_is_body        = r_out.is_body;
    assign o_done_res       = r_out.done_res;
    assign o_status         = r_out.status;
    assign o_capture_length = r_out.capture_length;

`ifndef SYNTHESIS
    // Skid entry is only used behind an occupied output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    // Status and length are zero on words that do not end a packet
    a_quiet_mid_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_done_res) |-> (o_status == ST_COMPLETE && o_capture_length == 8'd0))
        else $error("status reported on a non-final word");

    // Failure statuses carry no capture length
    a_fail_no_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_SHORT || o_status == ST_MISMATCH
                     || o_status == ST_NO_LINE)) |-> (o_capture_length == 8'd0))
        else $error("capture length on a failed packet");

    // Header bytes and bytes past the body window carry no body offset
    a_offset_in_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_body) |-> (o_body_offset == 8'd0))
        else $error("body offset outside the body window");
`endif

endmodule

`default_nettype wire

### tb/sv/ssdp_response_line_scanner_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SSDP response line scanner testbench
// Streams SSDP payload frames, one byte per word, into the scanner: a few
// hand-built frames first, then randomly shaped frames (well-formed replies,
// truncated replies, corrupted status lines, short frames, noise, window-edge
// and overlong frames). A tracker class predicts every result word and
// checks the words that come out, while the sender idles in bursts and the
// receiver stalls on patterns of its own.
// ----------------------------------------------------------------------------

// Track the scan of one frame at a time and check each result word in order
class line_scan_tracker;
    ssdp_pkg::t_result expected_words[$];
    int unsigned       error_count;
    int unsigned       window;
    logic [7:0]        status_line[17];

    logic [8:0]        byte_count;
    logic              header_ok;
    logic              scan_stopped;
    logic              pending_cr;
    logic              line_empty;
    logic              end_seen;
    logic [7:0]        lines_length;

    function new(int unsigned scan_window);
        string text;
        text = "HTTP/1.1 200 OK";
        window = scan_window;
        error_count = 0;
        for (int unsigned i = 0; i < 15; i++) status_line[i] = text[i];
        status_line[15] = ssdp_pkg::CHAR_CR;
        status_line[16] = ssdp_pkg::CHAR_LF;
        restart_frame();
    endfunction

    function void restart_frame();
        byte_count   = '0;
        header_ok    = 1'b1;
        scan_stopped = 1'b0;
        pending_cr   = 1'b0;
        line_empty   = 1'b1;
        end_seen     = 1'b0;
        lines_length = '0;
    endfunction

    // Advance the line scan by one body byte at body position pos
    function void scan_body(logic [7:0] data, int unsigned pos);
        if (scan_stopped) return;
        if (pending_cr) begin
            pending_cr = 1'b0;
            if (data == ssdp_pkg::CHAR_LF) begin
                lines_length = 8'(pos - 1);
                if (line_empty) begin
                    end_seen     = 1'b1;
                    scan_stopped = 1'b1;
                end else begin
                    line_empty = 1'b1;
                end
                return;
            end
            // a lone CR is an ordinary character
            line_empty = 1'b0;
        end
        if (pos >= window) begin
            scan_stopped = 1'b1;
            return;
        end
        if (data == ssdp_pkg::CHAR_CR) begin
            pending_cr = 1'b1;
        end else if (data == ssdp_pkg::CHAR_NUL || data[7]) begin
            scan_stopped = 1'b1;
        end else begin
            line_empty = 1'b0;
        end
    endfunction

    // Predict the result word for one accepted input word
    function void note_byte(logic [7:0] data, logic last);
        ssdp_pkg::t_result want;
        int unsigned       idx;
        int unsigned       pos;
        want = '0;
        idx  = byte_count;
        want.body_byte = data;
        want.done_res  = last;
        if (idx < ssdp_pkg::HDR_LEN) begin
            if (data != status_line[idx]) header_ok = 1'b0;
        end else begin
            pos = idx - ssdp_pkg::HDR_LEN;
            if (pos < window) begin
                want.is_body     = 1'b1;
                want.body_offset = 8'(pos);
            end
            scan_body(data, pos);
        end
        if (byte_count < 9'd511) byte_count++;
        if (last) begin
            if (idx + 1 < ssdp_pkg::MIN_LEN) begin
                want.status = ssdp_pkg::ST_SHORT;
            end else if (!header_ok) begin
                want.status = ssdp_pkg::ST_MISMATCH;
            end else if (lines_length == 0) begin
                want.status = ssdp_pkg::ST_NO_LINE;
            end else if (end_seen) begin
                want.status = ssdp_pkg::ST_COMPLETE;
            end else begin
                want.status = ssdp_pkg::ST_TRUNCATED;
            end
            if (want.status == ssdp_pkg::ST_COMPLETE || want.status == ssdp_pkg::ST_TRUNCATED)
                want.capture_length = lines_length;
            restart_frame();
        end
        expected_words.push_back(want);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Check one accepted result word against the oldest prediction
    function void check_word(ssdp_pkg::t_result got);
        ssdp_pkg::t_result want;
        if (expected_words.size() == 0) begin
            $display("%0t: result word %h with none expected", $time, got);
            error_count++;
            return;
        end
        want = expected_words.pop_front();
        compare_field("body_byte", want.body_byte, got.body_byte);
        compare_field("body_offset", want.body_offset, got.body_offset);
        compare_field("is_body", 8'(want.is_body), 8'(got.is_body));
        compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
        compare_field("status", 8'(want.status), 8'(got.status));
        compare_field("capture_length", want.capture_length, got.capture_length);
    endfunction
endclass

module ssdp_response_line_scanner_top_tb;
    import ssdp_pkg::*;

    localparam int unsigned SCAN_WINDOW    = MAX_DATA_DEF;
    localparam int unsigned ITEM_GOAL      = 1150;
    localparam int unsigned WATCHDOG_LIMIT = 200;

    typedef enum int unsigned {
        FR_COMPLETE,
        FR_TRUNCATED,
        FR_BAD_HEADER,
        FR_SHORT,
        FR_NOISE,
        FR_WINDOW,
        FR_OVERLONG,
        FR_KIND_COUNT
    } frame_kind_e;

    typedef enum int unsigned {
        RX_FREE,
        RX_RANDOM,
        RX_PERIODIC,
        RX_LONG
    } rx_mode_e;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_payload_byte;
    logic       i_last_byte;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_body_byte;
    logic [7:0] o_body_offset;
    logic       o_is_body;
    logic       o_done_res;
    logic [2:0] o_status;
    logic [7:0] o_capture_length;

    line_scan_tracker  tracker;
    t_result           observed;
    logic [7:0]        frame_q[$];
    int unsigned       burst_left = 0;
    logic              gaps_on = 1'b1;
    int unsigned       idle_cycles = 0;
    rx_mode_e          rx_mode = RX_FREE;
    int unsigned       rx_phase_left = 0;
    int unsigned       rx_run = 0;

    ssdp_response_line_scanner_top #(
        .MAX_DATA(SCAN_WINDOW)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_payload_byte  (i_payload_byte),
        .i_last_byte     (i_last_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_body_byte     (o_body_byte),
        .o_body_offset   (o_body_offset),
        .o_is_body       (o_is_body),
        .o_done_res      (o_done_res),
        .o_status        (o_status),
        .o_capture_length(o_capture_length)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Stall the result side, switching to a random pattern at the end of each random-length phase
    always @(posedge i_clk) begin
        if (rx_phase_left == 0) begin
            rx_mode       = rx_mode_e'($urandom_range(0, 3));
            rx_phase_left = $urandom_range(40, 200);
        end else begin
            rx_phase_left--;
        end
        case (rx_mode)
            RX_FREE:     i_stall <= 1'b0;
            RX_RANDOM:   i_stall <= ($urandom_range(0, 2) == 0);
            RX_PERIODIC: i_stall <= (rx_phase_left % 5 < 2);
            default: begin
                if (rx_run != 0) begin
                    rx_run--;
                    i_stall <= 1'b1;
                end else begin
                    i_stall <= 1'b0;
                    if ($urandom_range(0, 7) == 0) rx_run = $urandom_range(2, 10);
                end
            end
        endcase
    end

    // Predict on accepted input words, check accepted result words, watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) tracker.note_byte(i_payload_byte, i_last_byte);
        if (i_rst_n && o_valid && !i_stall) begin
            observed = {o_body_byte, o_body_offset, o_is_body, o_done_res, o_status,
                        o_capture_length};
            tracker.check_word(observed);
        end
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
            $display("[ssdp_response_line_scanner_top] ERROR");
            $finish;
        end
    end

    function automatic logic [7:0] text_char();
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    function automatic logic [7:0] stop_char();
        return ($urandom_range(0, 2) == 0) ? CHAR_NUL : 8'($urandom_range(8'h80, 8'hFF));
    endfunction

    function automatic void push_status_line();
        for (int unsigned i = 0; i < HDR_LEN; i++) frame_q.push_back(tracker.status_line[i]);
    endfunction

    function automatic void push_crlf();
        frame_q.push_back(CHAR_CR);
        frame_q.push_back(CHAR_LF);
    endfunction

    // Append header lines of short random text, now and then with a lone CR
    function automatic void push_lines(int unsigned n_lines);
        int unsigned len;
        for (int unsigned l = 0; l < n_lines; l++) begin
            len = $urandom_range(1, 6);
            for (int unsigned c = 0; c < len; c++) begin
                if ($urandom_range(0, 15) == 0) frame_q.push_back(CHAR_CR);
                frame_q.push_back(text_char());
            end
            push_crlf();
        end
    endfunction

    function automatic frame_kind_e pick_kind();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 34) return FR_COMPLETE;
        if (r < 56) return FR_TRUNCATED;
        if (r < 70) return FR_BAD_HEADER;
        if (r < 82) return FR_SHORT;
        if (r < 97) return FR_NOISE;
        return FR_WINDOW;
    endfunction

    // Build one payload frame of the given kind into frame_q
    function automatic void build_frame(frame_kind_e kind);
        int unsigned n;
        frame_q.delete();
        case (kind)
            FR_COMPLETE, FR_TRUNCATED, FR_BAD_HEADER: begin
                push_status_line();
                push_lines($urandom_range(0, 3));
                if (kind != FR_TRUNCATED) push_crlf();
                if ($urandom_range(0, 4) == 0)
                    frame_q.insert($urandom_range(HDR_LEN, frame_q.size()), stop_char());
                while (frame_q.size() < MIN_LEN) frame_q.push_back(text_char());
                repeat ($urandom_range(0, 3)) frame_q.push_back(8'($urandom));
                if (kind == FR_BAD_HEADER) begin
                    n = $urandom_range(0, HDR_LEN - 1);
                    frame_q[n] = frame_q[n] ^ 8'(1 << $urandom_range(0, 7));
                end
            end
            FR_SHORT: begin
                push_status_line();
                n = $urandom_range(1, MIN_LEN - 1);
                while (frame_q.size() > n) void'(frame_q.pop_back());
                while (frame_q.size() < n) frame_q.push_back(text_char());
            end
            FR_NOISE: begin
                repeat ($urandom_range(1, 40)) frame_q.push_back(8'($urandom));
            end
            FR_WINDOW: begin
                // fill the window, then land a CR on its last position and LF past it
                push_status_line();
                for (int unsigned p = 0; p < SCAN_WINDOW - 1; p++) begin
                    if (p < SCAN_WINDOW - 6 && p % 16 == 13) begin
                        frame_q.push_back(CHAR_CR);
                    end else if (p < SCAN_WINDOW - 6 && p % 16 == 14) begin
                        frame_q.push_back(CHAR_LF);
                    end else begin
                        frame_q.push_back(text_char());
                    end
                end
                push_crlf();
                repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom));
            end
            default: begin
                // run past the saturation point of the byte counter
                push_status_line();
                while (frame_q.size() < 520) push_lines(1);
                repeat ($urandom_range(1, 4)) frame_q.push_back(text_char());
            end
        endcase
    endfunction

    // Present one input word and hold it until it is taken
    task automatic send_word(input logic [7:0] data, input logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = gaps_on ? $urandom_range(1, 6) : 0;
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid        <= 1'b1;
        i_payload_byte <= data;
        i_last_byte    <= last;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_frame();
        for (int unsigned k = 0; k < frame_q.size(); k++)
            send_word(frame_q[k], k == frame_q.size() - 1);
    endtask

    // Hold off the sender until every predicted word has come out
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (tracker.expected_words.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int unsigned random_items;
        int unsigned frame_no;
        frame_kind_e kind;

        tracker = new(SCAN_WINDOW);
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_payload_byte <= '0;
        i_last_byte    <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: single-byte frames at both byte extremes, then a minimal reply
        frame_q = '{8'h00};
        send_frame();
        frame_q = '{8'hFF};
        send_frame();
        frame_q.delete();
        push_status_line();
        frame_q.push_back("A");
        push_crlf();
        push_crlf();
        send_frame();
        wait_drained();

        // Random: each kind once first, then a weighted mix
        random_items = 0;
        frame_no = 0;
        while (random_items < ITEM_GOAL) begin
            if (frame_no < FR_KIND_COUNT) begin
                kind = frame_kind_e'(frame_no);
            end else begin
                kind = pick_kind();
            end
            gaps_on = ($urandom_range(0, 3) != 0);
            build_frame(kind);
            send_frame();
            random_items += frame_q.size();
            if (frame_no % 8 == 7) wait_drained();
            frame_no++;
        end

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (tracker.error_count == 0) begin
            $display("[ssdp_response_line_scanner_top] OK");
        end else begin
            $display("[ssdp_response_line_scanner_top] ERROR");
        end
        $finish;
    end

endmodule

### sim.f
design/ssdp_pkg.sv
design/ssdp_scan.sv
design/ssdp_response_line_scanner_top.sv
tb/sv/ssdp_response_line_scanner_top_tb.sv
